[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on a rising
// edge and is switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication or expression that must hold at every clock edge.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// A condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

[rtl/cfs_pkg.sv]
package cfs_pkg;

    // Default coordinate width of the position and view fields.
    localparam int COORD_WIDTH_DEF = 16;

    // Width of the geometry registers and of the axis enable register.
    localparam int CFG_WIDTH      = 15;
    localparam int AXIS_EN_WIDTH  = 3;
    localparam int REG_IDX_WIDTH  = 3;

    typedef logic [REG_IDX_WIDTH-1:0] t_reg_idx;
    typedef logic [CFG_WIDTH-1:0]     t_cfg;
    typedef logic [AXIS_EN_WIDTH-1:0] t_axis_en;

    // Register map.
    localparam t_reg_idx REG_VIEW_WIDTH   = 3'd0;
    localparam t_reg_idx REG_VIEW_HEIGHT  = 3'd1;
    localparam t_reg_idx REG_MARGIN_X     = 3'd2;
    localparam t_reg_idx REG_MARGIN_Y     = 3'd3;
    localparam t_reg_idx REG_WORLD_WIDTH  = 3'd4;
    localparam t_reg_idx REG_WORLD_HEIGHT = 3'd5;
    localparam t_reg_idx REG_WORLD_DEPTH  = 3'd6;
    localparam t_reg_idx REG_AXIS_ENABLE  = 3'd7;

    // Register values after reset.
    localparam t_cfg     RST_VIEW_WIDTH   = 15'd320;
    localparam t_cfg     RST_VIEW_HEIGHT  = 15'd240;
    localparam t_cfg     RST_MARGIN_X     = 15'd160;
    localparam t_cfg     RST_MARGIN_Y     = 15'd120;
    localparam t_cfg     RST_WORLD_WIDTH  = 15'd320;
    localparam t_cfg     RST_WORLD_HEIGHT = 15'd240;
    localparam t_cfg     RST_WORLD_DEPTH  = 15'd0;
    localparam t_axis_en RST_AXIS_ENABLE  = 3'b111;

    // Bit positions in the axis enable register.
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

endpackage

[rtl/camera_follow_scroll.sv]
// Dead-zone camera follow. Each beat on the input channel carries the
// followed object's position and the current view origin; the block returns
// one beat holding the scroll increment for x, y and z and a move flag. An
// axis only scrolls when the object leaves the dead zone (margin_x/margin_y
// from the view edges, the view origin itself for z) while moving outward,
// judged from the position of the previous frame. The very first frame after
// reset snaps toward the object and clamps at the far map edge; later frames
// drop any increment that would carry the view off the map. Increments
// saturate to COORD_WIDTH+1 bits; move_request reflects the values before
// map-edge cancelling. With every axis disabled the result is all zero and
// the frame is not recorded. Each beat passes through one input register,
// one pass of per-axis compare and add logic, and the result register. A
// new beat is taken every cycle, also while a result waits to be taken, as
// long as the input register can move on; only the last-position registers
// are fed back, so nothing limits the rate below one beat per cycle. The
// registers are written through the configuration channel, always ready;
// the user must write only while no beat is in flight, which is unchecked.
module camera_follow_scroll
    import cfs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [REG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]   i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic signed [COORD_WIDTH-1:0] i_view_x,
    input  logic signed [COORD_WIDTH-1:0] i_view_y,
    input  logic signed [COORD_WIDTH-1:0] i_view_z,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [COORD_WIDTH:0] o_step_x,
    output logic signed [COORD_WIDTH:0] o_step_y,
    output logic signed [COORD_WIDTH:0] o_step_z,
    output logic                   o_move_request
);

`include "assert_macros.svh"

    // Internal arithmetic width: room for a coordinate or a register value
    // plus a few sums of them without overflow.
    localparam int BASE_W = (COORD_WIDTH > CFG_WIDTH) ? COORD_WIDTH : CFG_WIDTH;
    localparam int EW     = BASE_W + 4;
    localparam int SW     = COORD_WIDTH + 1;

    typedef logic signed [EW-1:0] t_wide;

    // Raw increment of one axis and whether it would leave the map.
    typedef struct packed {
        t_wide raw;
        logic  cancel;
    } t_axis;

    localparam t_wide SAT_HI = {{(EW-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};
    localparam t_wide SAT_LO = {{(EW-COORD_WIDTH){1'b1}}, {COORD_WIDTH{1'b0}}};

    function automatic t_wide sext(input logic [COORD_WIDTH-1:0] v);
        return {{(EW-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    function automatic t_wide zext(input logic [CFG_WIDTH-1:0] v);
        return {{(EW-CFG_WIDTH){1'b0}}, v};
    endfunction

    function automatic logic [SW-1:0] sat(input t_wide v);
        logic [SW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SW-1:0];
        end else begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    // Planar axis. The first-frame clamp sp + inc + sw > mw reduces to
    // pos + u > mw, and the view origin after a step is computed straight
    // from the target position, so the checks run side by side.
    function automatic t_axis plane_step(input t_wide pos, input t_wide sp,
                                         input t_wide sw, input t_wide u,
                                         input t_wide mw, input logic up,
                                         input logic dn, input logic seen);
        t_axis res;
        t_wide rel;
        t_wide lim;
        t_wide np;
        rel        = pos - sp;
        lim        = sw - u;
        np         = sp;
        res.raw    = '0;
        res.cancel = 1'b0;
        if (!seen) begin
            if (rel > lim) begin
                if (pos + u > mw) begin
                    res.raw = mw - sw - sp;
                end else begin
                    res.raw = rel - lim;
                end
            end
        end else begin
            if (rel > lim && up && sp < mw - sw) begin
                res.raw = rel - lim;
                np      = pos - lim;
            end
            if (rel < u && dn && sp > 0) begin
                res.raw = rel - u;
                np      = pos - u;
            end
            res.cancel = (np > mw - sw) || (np < 0);
        end
        return res;
    endfunction

    // Depth axis: no dead zone, the view origin follows the target itself.
    function automatic t_axis depth_step(input t_wide pos, input t_wide sp,
                                         input t_wide md, input logic up,
                                         input logic dn, input logic seen);
        t_axis res;
        t_wide rel;
        t_wide np;
        rel        = pos - sp;
        np         = sp;
        res.raw    = '0;
        res.cancel = 1'b0;
        if (!seen) begin
            if (rel > 0) begin
                if (pos > md) begin
                    res.raw = md - sp;
                end else begin
                    res.raw = rel;
                end
            end
        end else begin
            if (rel > 0 && up && sp < md) begin
                res.raw = rel;
                np      = pos;
            end
            if (rel < 0 && dn && sp > 0) begin
                res.raw = rel;
                np      = pos;
            end
            res.cancel = (np > md) || (np < 0);
        end
        return res;
    endfunction

    // Configuration registers.
    t_cfg     r_view_width;
    t_cfg     r_view_height;
    t_cfg     r_margin_x;
    t_cfg     r_margin_y;
    t_cfg     r_world_width;
    t_cfg     r_world_height;
    t_cfg     r_world_depth;
    t_axis_en r_axis_enable;

    // Input stage.
    logic                          r_in_vld;
    logic signed [COORD_WIDTH-1:0] r_tx;
    logic signed [COORD_WIDTH-1:0] r_ty;
    logic signed [COORD_WIDTH-1:0] r_tz;
    logic signed [COORD_WIDTH-1:0] r_vx;
    logic signed [COORD_WIDTH-1:0] r_vy;
    logic signed [COORD_WIDTH-1:0] r_vz;

    // Follow state.
    logic signed [COORD_WIDTH-1:0] r_prev_x;
    logic signed [COORD_WIDTH-1:0] r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_prev_z;
    logic                          r_seen;

    // Result stage.
    logic          r_out_vld;
    logic [SW-1:0] r_step_x;
    logic [SW-1:0] r_step_y;
    logic [SW-1:0] r_step_z;
    logic          r_move;

    logic          in_fire;
    logic          out_free;
    logic          adv;
    logic          any_en;
    logic          up_x;
    logic          dn_x;
    logic          up_y;
    logic          dn_y;
    logic          up_z;
    logic          dn_z;
    t_axis         ax_x;
    t_axis         ax_y;
    t_axis         ax_z;
    logic          n_move;
    logic [SW-1:0] n_step_x;
    logic [SW-1:0] n_step_y;
    logic [SW-1:0] n_step_z;

    // The result register frees up in the same cycle it is taken, so the
    // input register moves on whenever the output side accepts.
    assign out_free    = !r_out_vld || i_out_ready;
    assign adv         = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign any_en = |r_axis_enable;

    // Direction of travel relative to the last recorded frame.
    assign up_x = r_seen && (r_tx > r_prev_x);
    assign dn_x = r_seen && (r_tx < r_prev_x);
    assign up_y = r_seen && (r_ty > r_prev_y);
    assign dn_y = r_seen && (r_ty < r_prev_y);
    assign up_z = r_seen && (r_tz > r_prev_z);
    assign dn_z = r_seen && (r_tz < r_prev_z);

    always_comb begin
        ax_x = '0;
        ax_y = '0;
        ax_z = '0;
        if (r_axis_enable[AXIS_X]) begin
            ax_x = plane_step(sext(r_tx), sext(r_vx), zext(r_view_width),
                              zext(r_margin_x), zext(r_world_width),
                              up_x, dn_x, r_seen);
        end
        if (r_axis_enable[AXIS_Y]) begin
            ax_y = plane_step(sext(r_ty), sext(r_vy), zext(r_view_height),
                              zext(r_margin_y), zext(r_world_height),
                              up_y, dn_y, r_seen);
        end
        if (r_axis_enable[AXIS_Z]) begin
            ax_z = depth_step(sext(r_tz), sext(r_vz), zext(r_world_depth),
                              up_z, dn_z, r_seen);
        end
    end

    // A zero raw increment reads as zero whether cancelled or not, so the
    // cancel flag can be applied without looking at the move flag.
    always_comb begin
        n_move   = (ax_x.raw != '0) || (ax_y.raw != '0) || (ax_z.raw != '0);
        n_step_x = ax_x.cancel ? '0 : sat(ax_x.raw);
        n_step_y = ax_y.cancel ? '0 : sat(ax_y.raw);
        n_step_z = ax_z.cancel ? '0 : sat(ax_z.raw);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width   <= RST_VIEW_WIDTH;
            r_view_height  <= RST_VIEW_HEIGHT;
            r_margin_x     <= RST_MARGIN_X;
            r_margin_y     <= RST_MARGIN_Y;
            r_world_width  <= RST_WORLD_WIDTH;
            r_world_height <= RST_WORLD_HEIGHT;
            r_world_depth  <= RST_WORLD_DEPTH;
            r_axis_enable  <= RST_AXIS_ENABLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_VIEW_WIDTH:   r_view_width   <= i_cfg_data;
                REG_VIEW_HEIGHT:  r_view_height  <= i_cfg_data;
                REG_MARGIN_X:     r_margin_x     <= i_cfg_data;
                REG_MARGIN_Y:     r_margin_y     <= i_cfg_data;
                REG_WORLD_WIDTH:  r_world_width  <= i_cfg_data;
                REG_WORLD_HEIGHT: r_world_height <= i_cfg_data;
                REG_WORLD_DEPTH:  r_world_depth  <= i_cfg_data;
                REG_AXIS_ENABLE:  r_axis_enable  <= i_cfg_data[AXIS_EN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Control state: stage valids and the follow state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_prev_z  <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            // A frame with every axis disabled leaves no trace.
            if (adv && any_en) begin
                r_prev_x <= r_tx;
                r_prev_y <= r_ty;
                r_prev_z <= r_tz;
                r_seen   <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tx <= i_target_x;
            r_ty <= i_target_y;
            r_tz <= i_target_z;
            r_vx <= i_view_x;
            r_vy <= i_view_y;
            r_vz <= i_view_z;
        end
        if (adv) begin
            r_step_x <= n_step_x;
            r_step_y <= n_step_y;
            r_step_z <= n_step_z;
            r_move   <= n_move;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_step_x       = r_step_x;
    assign o_step_y       = r_step_y;
    assign o_step_z       = r_step_z;
    assign o_move_request = r_move;

    // Once a frame has been recorded the first-frame rule never returns.
    `ASSERT_CLK(a_seen_sticky, i_clk, i_rst_n, r_seen |=> r_seen)

    // Input is only held off when both stages are occupied.
    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n, !o_in_ready |-> (r_in_vld && r_out_vld))

    // Without a move request every increment must be zero.
    `ASSERT_NEVER(a_step_without_move, i_clk, i_rst_n,
        o_out_valid && !o_move_request &&
        (o_step_x != '0 || o_step_y != '0 || o_step_z != '0))

endmodule

[tb/sv/camera_follow_scroll_test.sv]
module camera_follow_scroll_test;
    import cfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int RESET_CYCLES = 6;
    // Slack after the last result so that no beat is left in the block.
    localparam int SETTLE_CYCLES = 4;
    // Cycles with no beat moved on any channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    localparam int CFG_MAX     = 32767;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 116;
    // The random phase that runs with both sides always willing.
    localparam int STEADY_PHASE = 2;

    localparam t_axis_en AXES_NONE = '0;
    localparam t_axis_en AXES_ALL  = '1;
    localparam t_axis_en AXES_X    = t_axis_en'(1 << AXIS_X);
    localparam t_axis_en AXES_YZ   = t_axis_en'((1 << AXIS_Y) | (1 << AXIS_Z));

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_step;

    // One input beat: where the followed object is and where the view sits.
    typedef struct {
        t_coord tx, ty, tz;
        t_coord vx, vy, vz;
    } t_frame;

    // One result beat: the scroll to apply and whether a move was asked for.
    typedef struct {
        t_step sx, sy, sz;
        logic  move;
    } t_scroll;

    // Software-visible geometry, one field per register.
    typedef struct {
        t_cfg     view_w, view_h;
        t_cfg     margin_x, margin_y;
        t_cfg     world_w, world_h, world_d;
        t_axis_en axes;
    } t_geometry;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    t_reg_idx i_cfg_index = '0;
    t_cfg     i_cfg_data = '0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_coord   i_target_x = '0;
    t_coord   i_target_y = '0;
    t_coord   i_target_z = '0;
    t_coord   i_view_x = '0;
    t_coord   i_view_y = '0;
    t_coord   i_view_z = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_step    o_step_x;
    t_step    o_step_y;
    t_step    o_step_z;
    logic     o_move_request;

    camera_follow_scroll #(
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_z     (i_target_z),
        .i_view_x       (i_view_x),
        .i_view_y       (i_view_y),
        .i_view_z       (i_view_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_x       (o_step_x),
        .o_step_y       (o_step_y),
        .o_step_z       (o_step_z),
        .o_move_request (o_move_request)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Our own copy of the block's state: the geometry registers, the target
    // position of the last recorded frame and whether any frame was recorded.
    t_geometry geom;
    t_coord    last_x = '0;
    t_coord    last_y = '0;
    t_coord    last_z = '0;
    bit        frame_seen = 1'b0;

    // Scrolls predicted for accepted frames, oldest first.
    t_scroll pending_scrolls[$];

    // When set, neither the frame sender nor the result receiver ever idles.
    bit steady = 1'b0;

    int mismatches = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int settings_applied = 0;
    int quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Scroll prediction
    // ------------------------------------------------------------------

    // Travel direction on one axis, judged against the last recorded frame.
    // Before anything has been recorded there is no direction at all.
    function automatic int heading(t_coord pos, t_coord last);
        if (!frame_seen) return 0;
        if (pos > last) return 1;
        if (pos < last) return -1;
        return 0;
    endfunction

    // Raw increment on x or y. The dead zone spans margin pixels from the
    // near view edge to span-margin from it. The first frame snaps the far
    // edge toward the object and clamps at the far map edge; later frames
    // only scroll when the object heads outward and the view has room.
    function automatic longint plane_scroll(longint pos, longint org, longint span,
                                            longint margin, longint world, int dir);
        longint rel;
        longint reach;
        longint inc;
        rel   = pos - org;
        reach = span - margin;
        inc   = 0;
        if (!frame_seen) begin
            if (rel > reach) begin
                inc = rel - reach;
                if (org + inc + span > world) begin
                    inc = world - span - org;
                end
            end
        end else begin
            if (rel > reach && dir == 1 && org < world - span) begin
                inc = rel - reach;
            end
            if (rel < margin && dir == -1 && org > 0) begin
                inc = rel - margin;
            end
        end
        return inc;
    endfunction

    // Raw increment on z, where the view origin itself is the dead zone.
    function automatic longint depth_scroll(longint pos, longint org, longint depth,
                                            int dir);
        longint rel;
        longint inc;
        rel = pos - org;
        inc = 0;
        if (!frame_seen) begin
            if (rel > 0) begin
                inc = rel;
                if (org + inc > depth) begin
                    inc = depth - org;
                end
            end
        end else begin
            if (rel > 0 && dir == 1 && org < depth) begin
                inc = rel;
            end
            if (rel < 0 && dir == -1 && org > 0) begin
                inc = rel;
            end
        end
        return inc;
    endfunction

    function automatic t_step saturate_step(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << COORD_W) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return t_step'(v);
    endfunction

    // Works out the result beat for one accepted frame and advances our state.
    function automatic t_scroll predict_scroll(t_frame f);
        t_scroll r;
        longint  ix, iy, iz;
        longint  sw, sh, mw, mh, md;
        r  = '{sx: '0, sy: '0, sz: '0, move: 1'b0};
        ix = 0;
        iy = 0;
        iz = 0;
        sw = geom.view_w;
        sh = geom.view_h;
        mw = geom.world_w;
        mh = geom.world_h;
        md = geom.world_d;

        // With every axis off the frame is answered with zeros and forgotten.
        if (geom.axes == AXES_NONE) return r;

        if (geom.axes[AXIS_X]) begin
            ix = plane_scroll(f.tx, f.vx, sw, geom.margin_x, mw, heading(f.tx, last_x));
        end
        if (geom.axes[AXIS_Y]) begin
            iy = plane_scroll(f.ty, f.vy, sh, geom.margin_y, mh, heading(f.ty, last_y));
        end
        if (geom.axes[AXIS_Z]) begin
            iz = depth_scroll(f.tz, f.vz, md, heading(f.tz, last_z));
        end

        // The move flag reflects the raw increments; after the first frame an
        // increment that would carry the view off the map is then dropped.
        if (ix != 0 || iy != 0 || iz != 0) begin
            r.move = 1'b1;
            if (frame_seen) begin
                if (f.vx + ix > mw - sw || f.vx + ix < 0) ix = 0;
                if (f.vy + iy > mh - sh || f.vy + iy < 0) iy = 0;
                if (f.vz + iz > md || f.vz + iz < 0) iz = 0;
            end
        end
        r.sx = saturate_step(ix);
        r.sy = saturate_step(iy);
        r.sz = saturate_step(iz);

        last_x     = f.tx;
        last_y     = f.ty;
        last_z     = f.tz;
        frame_seen = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic longint clip_coord(longint v);
        longint hi;
        hi = (longint'(1) << (COORD_W - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic t_frame frame_of(longint tx, longint ty, longint tz,
                                        longint vx, longint vy, longint vz);
        t_frame f;
        f.tx = t_coord'(clip_coord(tx));
        f.ty = t_coord'(clip_coord(ty));
        f.tz = t_coord'(clip_coord(tz));
        f.vx = t_coord'(clip_coord(vx));
        f.vy = t_coord'(clip_coord(vy));
        f.vz = t_coord'(clip_coord(vz));
        return f;
    endfunction

    function automatic t_geometry make_geometry(int vw, int vh, int mx, int my,
                                                int ww, int wh, int wd, t_axis_en axes);
        t_geometry g;
        g.view_w   = t_cfg'(vw);
        g.view_h   = t_cfg'(vh);
        g.margin_x = t_cfg'(mx);
        g.margin_y = t_cfg'(my);
        g.world_w  = t_cfg'(ww);
        g.world_h  = t_cfg'(wh);
        g.world_d  = t_cfg'(wd);
        g.axes     = axes;
        return g;
    endfunction

    // A register value pinned to one end of its range or drawn between them.
    function automatic int corner_value(int lo);
        case ($urandom_range(2))
            0: return lo;
            1: return CFG_MAX;
            default: return int'($urandom_range(CFG_MAX, lo));
        endcase
    endfunction

    // Mostly geometry where the object can really be followed around a map,
    // sometimes registers at the ends of their ranges. A margin wider than
    // the view and a map smaller than the view both turn up now and then.
    function automatic t_geometry random_geometry();
        t_geometry g;
        int        vw, vh;
        if ($urandom_range(99) < 25) begin
            g = make_geometry(corner_value(1), corner_value(1), corner_value(0),
                              corner_value(0), corner_value(0), corner_value(0),
                              corner_value(0), AXES_ALL);
        end else begin
            vw = int'($urandom_range(400, 16));
            vh = int'($urandom_range(300, 16));
            g = make_geometry(vw, vh,
                              ($urandom_range(9) == 0) ? int'($urandom_range(vw + 200, vw))
                                                        : int'($urandom_range(vw / 2, 0)),
                              ($urandom_range(9) == 0) ? int'($urandom_range(vh + 200, vh))
                                                        : int'($urandom_range(vh / 2, 0)),
                              ($urandom_range(9) == 0) ? int'($urandom_range(vw, 0))
                                                        : int'($urandom_range(3000, vw)),
                              ($urandom_range(9) == 0) ? int'($urandom_range(vh, 0))
                                                        : int'($urandom_range(2400, vh)),
                              int'($urandom_range(2000, 0)), AXES_ALL);
        end
        if ($urandom_range(1) == 0) begin
            g.axes = t_axis_en'($urandom_range(7));
        end
        return g;
    endfunction

    function automatic int drift(int reach);
        return int'($urandom_range(2 * reach)) - reach;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // Leaves i_cfg_valid high so that back-to-back writes need no second
    // assignment in one step; apply_config lowers it after the last write.
    task automatic write_reg(t_reg_idx idx, t_cfg value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes every register. Only called while no frame is in flight.
    task automatic apply_config(t_geometry g);
        write_reg(REG_VIEW_WIDTH,   g.view_w);
        write_reg(REG_VIEW_HEIGHT,  g.view_h);
        write_reg(REG_MARGIN_X,     g.margin_x);
        write_reg(REG_MARGIN_Y,     g.margin_y);
        write_reg(REG_WORLD_WIDTH,  g.world_w);
        write_reg(REG_WORLD_HEIGHT, g.world_h);
        write_reg(REG_WORLD_DEPTH,  g.world_d);
        write_reg(REG_AXIS_ENABLE,  t_cfg'(g.axes));
        i_cfg_valid <= 1'b0;
        geom = g;
        settings_applied++;
    endtask

    // Sends one frame beat, idling first at random, and records the scroll
    // it should produce. Valid stays high after the beat is taken; the next
    // call either reloads the payload or drops valid for an idle cycle.
    task automatic send_frame(t_frame f, output t_scroll pred);
        while (!steady && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_target_x <= f.tx;
        i_target_y <= f.ty;
        i_target_z <= f.tz;
        i_view_x   <= f.vx;
        i_view_y   <= f.vy;
        i_view_z   <= f.vz;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_scroll(f);
        pending_scrolls.push_back(pred);
        frames_sent++;
    endtask

    // Stops sending and waits until every predicted scroll has come back,
    // then lets the pipeline settle so that registers may be rewritten.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_scrolls.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frames with every axis off must not count as seen, so the frame after
    // them still takes the first-frame rule: snap toward the object and clamp
    // at the far map edge, with nothing cancelled afterwards.
    task automatic test_first_frame();
        t_scroll p;
        apply_config(make_geometry(320, 240, 160, 120, 320, 240, 0, AXES_NONE));
        send_frame(frame_of(32767, -32768, 32767, -32768, 32767, -32768), p);
        send_frame(frame_of(900, 900, 900, 0, 0, 0), p);
        drain();
        apply_config(make_geometry(320, 240, 100, 80, 1000, 800, 500, AXES_ALL));
        send_frame(frame_of(5000, 100, 700, 0, 0, 0), p);
        // Heading outward but the scroll would leave the map: flagged, then dropped.
        send_frame(frame_of(5100, 100, 700, 0, 0, 0), p);
        drain();
    endtask

    // Each direction on each axis, inside and outside the dead zone, with
    // and without the map edge stopping the scroll.
    task automatic test_follow_directions();
        t_scroll p;
        send_frame(frame_of(300, 150, 100, 0, 0, 0), p);      // x and z head back, no scroll
        send_frame(frame_of(250, 150, 400, 200, 0, 100), p);  // x left past margin, z out
        send_frame(frame_of(600, 300, 50, 200, 100, 100), p); // x right, y down, z back
        send_frame(frame_of(600, 300, 50, 200, 100, 100), p); // no motion at all
        send_frame(frame_of(1100, 20, 60, 650, 100, 10), p);  // x stopped by far edge
        send_frame(frame_of(10, 10, 40, 20, 5, 0), p);        // x stopped by near edge
        send_frame(frame_of(20, 900, 600, 0, 560, 490), p);   // y and z at far edges
        send_frame(frame_of(15, 895, 590, 0, 560, 490), p);
        drain();
    endtask

    // Registers and coordinates at the ends of their ranges, including a
    // margin wider than the view and a map smaller than the view.
    task automatic test_extreme_geometry();
        t_scroll p;
        apply_config(make_geometry(CFG_MAX, CFG_MAX, CFG_MAX, 0, CFG_MAX, 0, CFG_MAX,
                                   AXES_ALL));
        send_frame(frame_of(32767, -32768, 32767, -32768, 32767, -32768), p);
        send_frame(frame_of(-32768, 32767, -32768, 32767, -32768, 32767), p);
        send_frame(frame_of(0, 0, 0, 0, 0, 0), p);
        send_frame(frame_of(32767, 32767, 32767, 0, 0, 0), p);
        drain();
        apply_config(make_geometry(1, 1, 0, CFG_MAX, 0, CFG_MAX, 0, AXES_ALL));
        send_frame(frame_of(32767, 32767, 1, -32768, -32768, 0), p);
        send_frame(frame_of(-32768, -32768, -32768, 32767, 32767, 32767), p);
        send_frame(frame_of(5, 5, 5, 0, 0, 0), p);
        drain();
    endtask

    // Single axes switched off: their scroll is zero while the position is
    // still recorded; with all off nothing is recorded.
    task automatic test_axis_masks();
        t_axis_en masks[4];
        t_scroll  p;
        masks = '{AXES_X, AXES_YZ, AXES_NONE, AXES_ALL};
        foreach (masks[m]) begin
            apply_config(make_geometry(200, 150, 50, 40, 1200, 900, 700, masks[m]));
            send_frame(frame_of(400 + 100 * m, 300 + 80 * m, 200 + 60 * m, 100, 100, 100), p);
            send_frame(frame_of(40 - 10 * m, 60 - 10 * m, 50 - 10 * m, 100, 100, 100), p);
            drain();
        end
    endtask

    // Random geometry per phase. Most frames follow an object that wanders
    // about a map while the view is moved by the predicted scroll, as a game
    // loop would; some frames jump the view and the object, and the rest are
    // raw random coordinates.
    task automatic test_random_scenes();
        t_scroll p;
        t_frame  f;
        longint  tx, ty, tz, vx, vy, vz;
        longint  sw, sh, mw, mh, md;
        int      pick;
        bit      noise;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_config(random_geometry());
            steady = (phase == STEADY_PHASE);
            sw = geom.view_w;
            sh = geom.view_h;
            mw = geom.world_w;
            mh = geom.world_h;
            md = geom.world_d;
            vx = (mw > sw) ? longint'($urandom_range(mw - sw)) : 0;
            vy = (mh > sh) ? longint'($urandom_range(mh - sh)) : 0;
            vz = longint'($urandom_range(md));
            tx = vx + longint'($urandom_range(sw));
            ty = vy + longint'($urandom_range(sh));
            tz = vz + longint'($urandom_range(200));
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                pick  = int'($urandom_range(99));
                noise = (pick >= 85);
                if (pick < 70) begin
                    // Keep an axis still now and then so equal positions occur.
                    if ($urandom_range(5) != 0) tx = clip_coord(tx + drift(40));
                    if ($urandom_range(5) != 0) ty = clip_coord(ty + drift(40));
                    if ($urandom_range(5) != 0) tz = clip_coord(tz + drift(40));
                end else if (!noise) begin
                    vx = longint'($urandom_range(mw + 100)) - 50;
                    vy = longint'($urandom_range(mh + 100)) - 50;
                    vz = longint'($urandom_range(md + 100)) - 50;
                    tx = clip_coord(vx + longint'($urandom_range(sw + 200)) - 100);
                    ty = clip_coord(vy + longint'($urandom_range(sh + 200)) - 100);
                    tz = clip_coord(vz + longint'($urandom_range(400)) - 200);
                end
                if (noise) begin
                    f.tx = t_coord'($urandom);
                    f.ty = t_coord'($urandom);
                    f.tz = t_coord'($urandom);
                    f.vx = t_coord'($urandom);
                    f.vy = t_coord'($urandom);
                    f.vz = t_coord'($urandom);
                end else begin
                    f = frame_of(tx, ty, tz, vx, vy, vz);
                end
                send_frame(f, p);
                if (!noise) begin
                    vx = clip_coord(vx + p.sx);
                    vy = clip_coord(vy + p.sy);
                    vz = clip_coord(vz + p.sz);
                end
            end
            drain();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Result ready drops at random about 30 times in a hundred, except in the
    // steady phase.
    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 30);
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every result beat is matched against the oldest predicted scroll.
    always @(posedge i_clk) begin
        t_scroll want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_scrolls.size() == 0) begin
                $error("result beat with no frame waiting for it");
                mismatches++;
            end else begin
                want = pending_scrolls.pop_front();
                check_field("step_x", want.sx, o_step_x);
                check_field("step_y", want.sy, o_step_y);
                check_field("step_z", want.sz, o_step_z);
                check_field("move_request", want.move, o_move_request);
            end
        end
    end

    // Ends a hung run: too many cycles in a row with no beat on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame();
        test_follow_directions();
        test_extreme_geometry();
        test_axis_masks();
        test_random_scenes();

        $display("Ran %0d frames and checked %0d result beats under %0d register settings,",
                 frames_sent, results_seen, settings_applied);
        $display("covering first-frame snap, dead-zone follow, edge drop and axis masks.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/cfs_pkg.sv
rtl/camera_follow_scroll.sv
tb/sv/camera_follow_scroll_test.sv
